@@ rtl/core/wmse_pkg.sv @@
package wmse_pkg;

    localparam int SAMPLE_W = 24;
    localparam int WEIGHT_W = 16;
    // Magnitude bits of a weight that counts (always positive).
    localparam int MAG_W = WEIGHT_W - 1;
    localparam int MEAN_W = 24;
    localparam int OUT_W = 23;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
    localparam int SQ_W = 64;
    localparam int ROOT_W = SQ_W / 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int DEF_MAX_SLICE_LEN = 1024;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [MAG_W-1:0]           weight;
        logic                       last;
    } q_item_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MDIV,
        ST_PASS,
        ST_SDIV,
        ST_SSQRT,
        ST_ESQ,
        ST_EMUL,
        ST_EDIV,
        ST_ESQRT,
        ST_FIN
    } back_state_t;

endpackage

@@ rtl/core/wmse_front.sv @@
module wmse_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic signed [wmse_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [wmse_pkg::WEIGHT_W-1:0]  weight,
    input  logic                                  sample_ok,
    input  logic                                  weight_ok,
    input  logic                                  last_item,
    output logic                                  q_valid,
    output wmse_pkg::q_item_t                     q_item,
    input  logic                                  q_pop
);

    localparam int PTR_W = $clog2(wmse_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wmse_pkg::QUEUE_DEPTH + 1);

    wmse_pkg::q_item_t queue_reg [wmse_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             item_ok;
    logic             push;
    wmse_pkg::q_item_t new_item;

    // An item counts only with finite sample and weight and a positive weight.
    assign item_ok = sample_ok && weight_ok && !weight[wmse_pkg::WEIGHT_W-1]
                     && (weight != '0);

    always_comb begin
        new_item.sample = sample;
        new_item.weight = item_ok ? weight[wmse_pkg::MAG_W-1:0] : '0;
        new_item.last   = last_item;
    end

    assign s_tready = (count_reg != CNT_W'(wmse_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/wmse_div.sv @@
module wmse_div #(
    parameter int NUM_W = 89,
    parameter int DEN_W = 52
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] n_reg;
    logic [DEN_W-1:0] r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Restoring division, one quotient bit per cycle; the quotient shifts
    // into the numerator register as its bits are consumed.
    assign trial = {r_reg, n_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, d_reg});
    assign done  = busy_reg && (cnt_reg == '0);
    assign quot  = n_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end else if (busy_reg && (cnt_reg != '0)) begin
            r_reg <= ge ? DEN_W'(trial - {1'b0, d_reg}) : trial[DEN_W-1:0];
            n_reg <= {n_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ rtl/core/wmse_sqrt.sv @@
module wmse_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wmse_pkg::SQ_W-1:0]     operand,
    output logic                          done,
    output logic [wmse_pkg::ROOT_W-1:0]   root
);

    localparam int SQ_W = wmse_pkg::SQ_W;
    localparam logic [SQ_W-1:0] TOP_BIT = {2'b01, {(SQ_W-2){1'b0}}};

    logic            busy_reg;
    logic [SQ_W-1:0] v_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [SQ_W-1:0] trial;

    // Digit-by-digit integer square root, one result bit per cycle.
    assign trial = res_reg + bit_reg;
    assign done  = busy_reg && (bit_reg == '0);
    assign root  = res_reg[wmse_pkg::ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= operand;
            res_reg <= '0;
            bit_reg <= TOP_BIT;
        end else if (busy_reg && (bit_reg != '0)) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/core/wmse_back.sv @@
module wmse_back #(
    parameter int MAX_SLICE_LEN = wmse_pkg::DEF_MAX_SLICE_LEN
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  wmse_pkg::q_item_t                   q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [wmse_pkg::MEAN_W-1:0]  mean,
    output logic [wmse_pkg::OUT_W-1:0]          std_dev,
    output logic [wmse_pkg::OUT_W-1:0]          mean_error,
    output logic                                no_valid,
    output logic                                overflowed
);

    localparam int SAMPLE_W = wmse_pkg::SAMPLE_W;
    localparam int MAG_W    = wmse_pkg::MAG_W;
    localparam int MEAN_W   = wmse_pkg::MEAN_W;
    localparam int OUT_W    = wmse_pkg::OUT_W;
    localparam int ROOT_W   = wmse_pkg::ROOT_W;
    localparam int CNT_W    = $clog2(MAX_SLICE_LEN + 1);
    localparam int ADDR_W   = $clog2(MAX_SLICE_LEN);
    localparam int XW_W     = SAMPLE_W + MAG_W + 1;
    localparam int WT_W     = MAG_W + CNT_W;
    localparam int WS_W     = SAMPLE_W + MAG_W + CNT_W;
    localparam int WQ_W     = 2 * MAG_W + CNT_W;
    localparam int AD_W     = SAMPLE_W;
    localparam int SQD_W    = 2 * AD_W;
    localparam int PR_W     = SQD_W + MAG_W;
    localparam int ACC_W    = PR_W + CNT_W;
    localparam int STDSQ_W  = 2 * OUT_W;
    localparam int PROD_W   = STDSQ_W + WQ_W;
    // The error numerator is the widest of the three divisions.
    localparam int NUM_W    = PROD_W + 2;
    localparam int DEN_W    = 2 * WT_W;

    wmse_pkg::back_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] sample_mem [MAX_SLICE_LEN];
    logic [MAG_W-1:0]           weight_mem [MAX_SLICE_LEN];

    logic [CNT_W-1:0]         fill_reg;
    logic [WT_W-1:0]          wt_reg;
    logic signed [WS_W-1:0]   ws_reg;
    logic [WQ_W-1:0]          wq_reg;
    logic                     ovf_reg;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [OUT_W-1:0]         std_reg;
    logic [OUT_W-1:0]         err_reg;
    logic                     nv_reg;
    logic                     launched_reg;

    logic [CNT_W-1:0]           rd_idx_reg;
    logic [3:0]                 pv_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic [MAG_W-1:0]           w1_reg;
    logic [AD_W-1:0]            ad2_reg;
    logic [MAG_W-1:0]           w2_reg;
    logic [SQD_W-1:0]           sq3_reg;
    logic [MAG_W-1:0]           w3_reg;
    logic [PR_W-1:0]            pr4_reg;

    logic [STDSQ_W-1:0] mplier_reg;
    logic [PROD_W-1:0]  mcand_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DEN_W-1:0]   swsq_reg;

    logic                       m_valid_reg;
    logic signed [MEAN_W-1:0]   m_mean_reg;
    logic [OUT_W-1:0]           m_std_reg;
    logic [OUT_W-1:0]           m_err_reg;
    logic                       m_nv_reg;
    logic                       m_ovf_reg;

    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [ROOT_W-1:0]  rounded;
    logic [OUT_W-1:0]   clamped;

    logic                       wr_en;
    logic                       issue;
    logic                       pass_done;
    logic signed [XW_W-1:0]     xw;
    logic [2*MAG_W-1:0]         ww;
    logic [WS_W-1:0]            ws_mag;
    logic [MEAN_W-1:0]          q_mean;
    logic signed [SAMPLE_W:0]   dev;
    logic                       out_free;

    wmse_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    wmse_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (div_quot[wmse_pkg::SQ_W-1:0]),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign wr_en     = q_pop && (fill_reg != CNT_W'(MAX_SLICE_LEN));
    assign xw        = q_item.sample * $signed({1'b0, q_item.weight});
    assign ww        = q_item.weight * q_item.weight;
    assign ws_mag    = ws_reg[WS_W-1] ? WS_W'(-ws_reg) : WS_W'(ws_reg);
    assign q_mean    = div_quot[MEAN_W-1:0];
    assign issue     = (state_reg == wmse_pkg::ST_PASS) && (rd_idx_reg != fill_reg);
    assign pass_done = (rd_idx_reg == fill_reg) && (pv_reg == '0);
    assign dev       = {x1_reg[SAMPLE_W-1], x1_reg} - {mean_reg[MEAN_W-1], mean_reg};
    // Round half up after the doubled square root, then saturate.
    assign rounded   = ROOT_W'(({1'b0, sqrt_root} + 1'b1) >> 1);
    assign clamped   = (rounded > ROOT_W'(wmse_pkg::OUT_MAX)) ? wmse_pkg::OUT_MAX
                       : rounded[OUT_W-1:0];
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = 1'b0;
        case (state_reg)
            wmse_pkg::ST_LOAD: begin
                q_pop = q_valid;
                if (q_valid && q_item.last) begin
                    state_next = wmse_pkg::ST_MDIV;
                end
            end
            wmse_pkg::ST_MDIV: begin
                div_num = NUM_W'({ws_mag, 1'b0}) + NUM_W'(wt_reg);
                div_den = DEN_W'({wt_reg, 1'b0});
                if (wt_reg == '0) begin
                    state_next = wmse_pkg::ST_FIN;
                end else if (!launched_reg) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    state_next = wmse_pkg::ST_PASS;
                end
            end
            wmse_pkg::ST_PASS: begin
                if (pass_done) begin
                    state_next = wmse_pkg::ST_SDIV;
                end
            end
            wmse_pkg::ST_SDIV: begin
                div_num = NUM_W'({acc_reg, 2'b00});
                div_den = DEN_W'(wt_reg);
                if (!launched_reg) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    state_next = wmse_pkg::ST_SSQRT;
                end
            end
            wmse_pkg::ST_SSQRT: begin
                if (!launched_reg) begin
                    sqrt_start = 1'b1;
                end else if (sqrt_done) begin
                    state_next = wmse_pkg::ST_ESQ;
                end
            end
            wmse_pkg::ST_ESQ: begin
                state_next = wmse_pkg::ST_EMUL;
            end
            wmse_pkg::ST_EMUL: begin
                if (mplier_reg == '0) begin
                    state_next = wmse_pkg::ST_EDIV;
                end
            end
            wmse_pkg::ST_EDIV: begin
                div_num = {prod_reg, 2'b00};
                div_den = swsq_reg;
                if (!launched_reg) begin
                    div_start = 1'b1;
                end else if (div_done) begin
                    state_next = wmse_pkg::ST_ESQRT;
                end
            end
            wmse_pkg::ST_ESQRT: begin
                if (!launched_reg) begin
                    sqrt_start = 1'b1;
                end else if (sqrt_done) begin
                    state_next = wmse_pkg::ST_FIN;
                end
            end
            wmse_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = wmse_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = wmse_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wmse_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Slice store: written in arrival order, read back during the second pass.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_mem[fill_reg[ADDR_W-1:0]] <= q_item.sample;
            weight_mem[fill_reg[ADDR_W-1:0]] <= q_item.weight;
        end
        x1_reg <= sample_mem[rd_idx_reg[ADDR_W-1:0]];
        w1_reg <= weight_mem[rd_idx_reg[ADDR_W-1:0]];
    end

    // Second-pass datapath: deviation, square, weighting, accumulation.
    always_ff @(posedge aclk) begin
        ad2_reg <= dev[SAMPLE_W] ? AD_W'(-dev) : AD_W'(dev);
        w2_reg  <= w1_reg;
        sq3_reg <= ad2_reg * ad2_reg;
        w3_reg  <= w2_reg;
        pr4_reg <= sq3_reg * w3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            wt_reg       <= '0;
            ws_reg       <= '0;
            wq_reg       <= '0;
            ovf_reg      <= 1'b0;
            launched_reg <= 1'b0;
            rd_idx_reg   <= '0;
            pv_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (div_start || sqrt_start) begin
                launched_reg <= 1'b1;
            end else if (div_done || sqrt_done) begin
                launched_reg <= 1'b0;
            end

            if (q_pop) begin
                if (wr_en) begin
                    fill_reg <= fill_reg + 1'b1;
                    wt_reg   <= wt_reg + WT_W'(q_item.weight);
                    ws_reg   <= ws_reg + {{(WS_W-XW_W){xw[XW_W-1]}}, xw};
                    wq_reg   <= wq_reg + WQ_W'(ww);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end

            if ((state_reg == wmse_pkg::ST_MDIV) && div_done) begin
                rd_idx_reg <= '0;
                pv_reg     <= '0;
            end else if (state_reg == wmse_pkg::ST_PASS) begin
                pv_reg <= {pv_reg[2:0], issue};
                if (issue) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end

            if ((state_reg == wmse_pkg::ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
                fill_reg    <= '0;
                wt_reg      <= '0;
                ws_reg      <= '0;
                wq_reg      <= '0;
                ovf_reg     <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            wmse_pkg::ST_MDIV: begin
                nv_reg  <= (wt_reg == '0);
                acc_reg <= '0;
                if (wt_reg == '0) begin
                    mean_reg <= '0;
                    std_reg  <= '0;
                    err_reg  <= '0;
                end else if (div_done) begin
                    mean_reg <= ws_reg[WS_W-1] ? MEAN_W'(-q_mean) : q_mean;
                end
            end
            wmse_pkg::ST_PASS: begin
                if (pv_reg[3]) begin
                    acc_reg <= acc_reg + ACC_W'(pr4_reg);
                end
            end
            wmse_pkg::ST_SSQRT: begin
                if (sqrt_done) begin
                    std_reg <= clamped;
                end
            end
            wmse_pkg::ST_ESQ: begin
                mplier_reg <= std_reg * std_reg;
                swsq_reg   <= wt_reg * wt_reg;
                mcand_reg  <= PROD_W'(wq_reg);
                prod_reg   <= '0;
            end
            wmse_pkg::ST_EMUL: begin
                // Shift-and-add product of the squared standard deviation and sum w^2.
                if (mplier_reg[0]) begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mplier_reg <= mplier_reg >> 1;
                mcand_reg  <= mcand_reg << 1;
            end
            wmse_pkg::ST_ESQRT: begin
                if (sqrt_done) begin
                    err_reg <= clamped;
                end
            end
            wmse_pkg::ST_FIN: begin
                if (out_free) begin
                    m_mean_reg <= mean_reg;
                    m_std_reg  <= std_reg;
                    m_err_reg  <= err_reg;
                    m_nv_reg   <= nv_reg;
                    m_ovf_reg  <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid   = m_valid_reg;
    assign mean       = m_mean_reg;
    assign std_dev    = m_std_reg;
    assign mean_error = m_err_reg;
    assign no_valid   = m_nv_reg;
    assign overflowed = m_ovf_reg;

endmodule

@@ rtl/core/weighted_mean_std_error_core.sv @@
// Channel  Direction  tdata (low bit first)                       tuser / tlast
// s_       in         sample[23:0], weight[39:24], pad to 48    tuser: sample_ok, weight_ok;
//                                                                tlast: last_item
// m_       out        mean[23:0], std_dev[46:24],               tuser: no_valid, overflowed
//                     mean_error[69:47], pad to 72
//
// The back end stores and accumulates each item that fits in the slice memory as it pops it.
// After the last item of a slice the result is computed by, in order, a
// serial division for the mean (one bit per cycle, like the other two), the
// pass over the slice memory, a division and a square root for std_dev, a
// shift-and-add multiply, and a division and a square root for mean_error.
// A four-entry queue keeps taking items, until it is full, while the back end computes or the
// result waits on m_tready. Reset is synchronous and active low.
module weighted_mean_std_error_core #(
    parameter int MAX_SLICE_LEN = wmse_pkg::DEF_MAX_SLICE_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample, weight, zero pad
    input  logic [1:0]  s_tuser,   // sample_ok, weight_ok
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // mean, std_dev, mean_error, zero pad
    output logic [1:0]  m_tuser    // no_valid, overflowed
);

    logic              q_valid;
    logic              q_pop;
    wmse_pkg::q_item_t q_item;
    logic signed [wmse_pkg::MEAN_W-1:0] mean;
    logic [wmse_pkg::OUT_W-1:0]         std_dev;
    logic [wmse_pkg::OUT_W-1:0]         mean_error;
    logic                               no_valid;
    logic                               overflowed;

    wmse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    ($signed(s_tdata[23:0])),
        .weight    ($signed(s_tdata[39:24])),
        .sample_ok (s_tuser[0]),
        .weight_ok (s_tuser[1]),
        .last_item (s_tlast),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    wmse_back #(
        .MAX_SLICE_LEN (MAX_SLICE_LEN)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .mean       (mean),
        .std_dev    (std_dev),
        .mean_error (mean_error),
        .no_valid   (no_valid),
        .overflowed (overflowed)
    );

    assign m_tdata = {2'b00, mean_error, std_dev, mean};
    assign m_tuser = {overflowed, no_valid};

`ifndef SYNTH
    // The back end never takes an item from an empty queue.
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Back-pressure on the input only comes from a queue holding items.
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("input stalled with an empty queue");

    // A new result is never loaded over one that has not been taken.
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result changed");
`endif

endmodule
